// ===== sv/fasu_pkg.sv =====
`default_nettype none
package fasu_pkg;
    localparam int unsigned STATUS_BITS = 2;
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;
endpackage
`default_nettype wire

// ===== sv/fasu_align.sv =====
`default_nettype none
// Stage 1: unpack, zero detect, order operands, register.
// Stage 2: truncating right shift of the smaller mantissa, register.
module fasu_align #(
    parameter int EXP_BITS  = 8,
    parameter int MANT_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic                        i_op,
    input  wire logic [EXP_BITS+MANT_BITS:0] i_a,
    input  wire logic [EXP_BITS+MANT_BITS:0] i_b,
    output logic                             o_valid,
    output logic                             o_bypass,
    output logic [EXP_BITS+MANT_BITS:0]      o_bypass_word,
    output logic                             o_sl,
    output logic                             o_ss,
    output logic [EXP_BITS-1:0]              o_el,
    output logic [MANT_BITS-1:0]             o_ml,
    output logic [MANT_BITS-1:0]             o_sh
);
    localparam int W = EXP_BITS + MANT_BITS + 1;

    logic                 sa, sb, za, zb, a_big;
    logic [EXP_BITS-1:0]  ea, eb, d;
    logic [MANT_BITS-1:0] ma, mb;

    logic                 r1_valid, r1_zero_case, r1_sl, r1_ss;
    logic [W-1:0]         r1_word;
    logic [EXP_BITS-1:0]  r1_el, r1_d;
    logic [MANT_BITS-1:0] r1_ml, r1_ms;

    logic [MANT_BITS-1:0] sh;
    logic                 r2_valid, r2_bypass, r2_sl, r2_ss;
    logic [W-1:0]         r2_word;
    logic [EXP_BITS-1:0]  r2_el;
    logic [MANT_BITS-1:0] r2_ml, r2_sh;

    always_comb begin
        sa = i_a[W-1];
        sb = i_b[W-1] ^ i_op;
        ea = i_a[W-2:MANT_BITS];
        eb = i_b[W-2:MANT_BITS];
        ma = i_a[MANT_BITS-1:0];
        mb = i_b[MANT_BITS-1:0];
        za = (ea == '0) && (ma == '0);
        zb = (eb == '0) && (mb == '0);
        a_big = (ea > eb) || ((ea == eb) && (ma >= mb));
        d = a_big ? (ea - eb) : (eb - ea);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_zero_case <= za || zb;
            if (za && zb) begin
                r1_word <= '0;
            end else if (za) begin
                r1_word <= {sb, i_b[W-2:0]};
            end else begin
                r1_word <= i_a;
            end
            r1_sl <= a_big ? sa : sb;
            r1_ss <= a_big ? sb : sa;
            r1_el <= a_big ? ea : eb;
            r1_ml <= a_big ? ma : mb;
            r1_ms <= a_big ? mb : ma;
            r1_d  <= d;
        end
    end

    always_comb begin
        if ({{(32-EXP_BITS){1'b0}}, r1_d} >= 32'(MANT_BITS)) begin
            sh = '0;
        end else begin
            sh = r1_ms >> r1_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // shifted out entirely: larger operand with its effective sign
            r2_bypass <= r1_zero_case || (sh == '0);
            r2_word   <= r1_zero_case ? r1_word : {r1_sl, r1_el, r1_ml};
            r2_sl     <= r1_sl;
            r2_ss     <= r1_ss;
            r2_el     <= r1_el;
            r2_ml     <= r1_ml;
            r2_sh     <= sh;
        end
    end

    assign o_valid       = r2_valid;
    assign o_bypass      = r2_bypass;
    assign o_bypass_word = r2_word;
    assign o_sl          = r2_sl;
    assign o_ss          = r2_ss;
    assign o_el          = r2_el;
    assign o_ml          = r2_ml;
    assign o_sh          = r2_sh;
endmodule
`default_nettype wire

// ===== sv/fasu_norm.sv =====
`default_nettype none
// Stage 3: add/subtract and leading-zero count. Stage 4: normalize and pack.
module fasu_norm
    import fasu_pkg::*;
#(
    parameter int EXP_BITS  = 8,
    parameter int MANT_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic                        i_bypass,
    input  wire logic [EXP_BITS+MANT_BITS:0] i_bypass_word,
    input  wire logic                        i_sl,
    input  wire logic                        i_ss,
    input  wire logic [EXP_BITS-1:0]         i_el,
    input  wire logic [MANT_BITS-1:0]        i_ml,
    input  wire logic [MANT_BITS-1:0]        i_sh,
    output logic                             o_valid,
    output logic [EXP_BITS+MANT_BITS:0]      o_result,
    output logic [STATUS_BITS-1:0]           o_status
);
    localparam int W      = EXP_BITS + MANT_BITS + 1;
    localparam int LZ_W   = $clog2(MANT_BITS + 1);
    localparam int E_EXT  = (EXP_BITS > LZ_W ? EXP_BITS : LZ_W) + 1;

    logic [MANT_BITS:0]   sum;
    logic [MANT_BITS-1:0] diff;
    logic                 ds;
    logic [LZ_W-1:0]      lz;

    logic                 r_valid, r_bypass, r_add, r_s;
    logic [W-1:0]         r_word;
    logic [EXP_BITS-1:0]  r_el;
    logic [MANT_BITS:0]   r_sum;
    logic [MANT_BITS-1:0] r_diff;
    logic [LZ_W-1:0]      r_lz;

    logic [W-1:0]           n_result;
    logic [STATUS_BITS-1:0] n_status;
    logic [E_EXT-1:0]       e_ext, lz_ext;
    logic [MANT_BITS-1:0]   mnorm;

    logic                   r_out_valid;
    logic [W-1:0]           r_result;
    logic [STATUS_BITS-1:0] r_status;

    always_comb begin
        sum = {1'b0, i_ml} + {1'b0, i_sh};
        if (i_ml >= i_sh) begin
            diff = i_ml - i_sh;
            ds   = i_sl;
        end else begin
            diff = i_sh - i_ml;
            ds   = i_ss;
        end
        lz = LZ_W'(MANT_BITS);
        for (int k = 0; k < MANT_BITS; k++) begin
            if (diff[k]) begin
                lz = LZ_W'(MANT_BITS - 1 - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bypass <= i_bypass;
            r_word   <= i_bypass_word;
            r_add    <= (i_sl == i_ss);
            r_s      <= (i_sl == i_ss) ? i_sl : ds;
            r_el     <= i_el;
            r_sum    <= sum;
            r_diff   <= diff;
            r_lz     <= lz;
        end
    end

    always_comb begin
        n_status = ST_OK;
        e_ext    = E_EXT'(r_el);
        lz_ext   = E_EXT'(r_lz);
        mnorm    = r_diff << r_lz;
        n_result = '0;
        if (r_bypass) begin
            n_result = r_word;
        end else if (r_add) begin
            if (r_sum[MANT_BITS]) begin
                if (r_el == '1) begin
                    n_status = ST_OVERFLOW;
                    n_result = {r_s, {EXP_BITS{1'b1}}, {MANT_BITS{1'b1}}};
                end else begin
                    n_result = {r_s, r_el + 1'b1, r_sum[MANT_BITS:1]};
                end
            end else begin
                n_result = {r_s, r_el, r_sum[MANT_BITS-1:0]};
            end
        end else if (r_diff == '0) begin
            n_result = '0;
        end else if (lz_ext > e_ext) begin
            n_status = ST_UNDERFLOW;
            n_result = '0;
        end else begin
            n_result = {r_s, EXP_BITS'(e_ext - lz_ext), mnorm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;
    assign o_status = r_status;
endmodule
`default_nettype wire

// ===== sv/float_add_sub_unit.sv =====
// Four-stage pipeline from input transaction to result.
// Throughput one transaction per cycle; the whole pipe advances whenever the
// output stage is empty or being taken (global enable on m_axis_tready).
// Reset (i_rst_n low, synchronous) clears all stage valid bits.
`default_nettype none
module float_add_sub_unit
    import fasu_pkg::*;
#(
    parameter int EXP_BITS  = 8,
    parameter int MANT_BITS = 24
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,
    // [0] operation, then operand_a, then operand_b; zero-padded to bytes
    input  wire logic [((2*(EXP_BITS+MANT_BITS+1)+1+7)/8)*8-1:0] s_axis_tdata,
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    // result, then status; zero-padded to bytes
    output logic [((EXP_BITS+MANT_BITS+1+STATUS_BITS+7)/8)*8-1:0] m_axis_tdata
);
    localparam int W   = EXP_BITS + MANT_BITS + 1;
    localparam int IW  = ((2*W+1+7)/8)*8;
    localparam int OW  = ((W+STATUS_BITS+7)/8)*8;

    logic                 en;
    logic                 a_valid, a_bypass, a_sl, a_ss;
    logic [W-1:0]         a_word;
    logic [EXP_BITS-1:0]  a_el;
    logic [MANT_BITS-1:0] a_ml, a_sh;
    logic [W-1:0]         res;
    logic [STATUS_BITS-1:0] st;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    fasu_align #(.EXP_BITS(EXP_BITS), .MANT_BITS(MANT_BITS)) u_align (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid), .i_op(s_axis_tdata[0]),
        .i_a(s_axis_tdata[W:1]), .i_b(s_axis_tdata[2*W:W+1]),
        .o_valid(a_valid), .o_bypass(a_bypass), .o_bypass_word(a_word),
        .o_sl(a_sl), .o_ss(a_ss), .o_el(a_el), .o_ml(a_ml), .o_sh(a_sh)
    );

    fasu_norm #(.EXP_BITS(EXP_BITS), .MANT_BITS(MANT_BITS)) u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(a_valid), .i_bypass(a_bypass), .i_bypass_word(a_word),
        .i_sl(a_sl), .i_ss(a_ss), .i_el(a_el), .i_ml(a_ml), .i_sh(a_sh),
        .o_valid(m_axis_tvalid), .o_result(res), .o_status(st)
    );

    assign m_axis_tdata = OW'({st, res});

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[IW-1:2*W+1];
endmodule
`default_nettype wire

// ===== sv/fasu_checker.sv =====
`default_nettype none
module fasu_checker
    import fasu_pkg::*;
#(
    parameter int EXP_BITS  = 8,
    parameter int MANT_BITS = 24
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [((EXP_BITS+MANT_BITS+1+STATUS_BITS+7)/8)*8-1:0] m_axis_tdata
);
    localparam int W = EXP_BITS + MANT_BITS + 1;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while pipe output empty");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[W+STATUS_BITS-1:W] <= ST_UNDERFLOW)
        else $error("illegal status code");
    a_uflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[W+STATUS_BITS-1:W] == ST_UNDERFLOW
        |-> m_axis_tdata[W-1:0] == '0)
        else $error("underflow without zero result");
endmodule

bind float_add_sub_unit fasu_checker #(.EXP_BITS(EXP_BITS), .MANT_BITS(MANT_BITS))
u_fasu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/float_add_sub_unit_tb.sv =====
`default_nettype none
module float_add_sub_unit_tb;
    import fasu_pkg::*;

    localparam int EB = 8;
    localparam int MB = 24;
    localparam int WB = EB + MB + 1;
    localparam int IN_W = ((2*WB+1+7)/8)*8;
    localparam int OUT_W = ((WB+STATUS_BITS+7)/8)*8;
    localparam int N_RANDOM = 1030;
    localparam int WATCHDOG = 5000;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    typedef struct packed {
        logic [WB-1:0] result;
        t_status       status;
    } fp_result_t;

    typedef struct {
        logic          op;
        logic [WB-1:0] a;
        logic [WB-1:0] b;
        logic          known;
        fp_result_t    res;
    } vec_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    float_add_sub_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // [0] operation, [33:1] operand_a, [66:34] operand_b
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // [32:0] result, [34:33] status
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    fp_result_t expected_q[$];
    int errors = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 55;
    int quiet_cycles = 0;

    function automatic logic [WB-1:0] fp_pack(logic s, logic [EB:0] e, logic [MB:0] m);
        return {s, e[EB-1:0], m[MB-1:0]};
    endfunction

    function automatic fp_result_t fp_add_sub(logic op, logic [WB-1:0] a, logic [WB-1:0] b);
        fp_result_t r;
        logic sa, sb, sl, ss, s, a_big;
        logic [EB-1:0] ea, eb, el, es;
        logic [MB-1:0] ma, mb, ml, ms, sh, diff;
        logic [MB:0] sum;
        logic [EB:0] e;
        int d, lz;
        sa = a[WB-1];
        sb = b[WB-1] ^ op;
        ea = a[WB-2:MB]; ma = a[MB-1:0];
        eb = b[WB-2:MB]; mb = b[MB-1:0];
        r.result = '0;
        r.status = ST_OK;
        if (ea == 0 && ma == 0 && eb == 0 && mb == 0) return r;
        if (ea == 0 && ma == 0) begin
            r.result = {sb, eb, mb};
            return r;
        end
        if (eb == 0 && mb == 0) begin
            r.result = a;
            return r;
        end
        a_big = (ea > eb) || (ea == eb && ma >= mb);
        sl = a_big ? sa : sb; ss = a_big ? sb : sa;
        el = a_big ? ea : eb; es = a_big ? eb : ea;
        ml = a_big ? ma : mb; ms = a_big ? mb : ma;
        d = int'(el) - int'(es);
        sh = (d >= MB) ? '0 : (ms >> d);
        if (sh == 0) begin
            r.result = {sl, el, ml};
        end else if (sl == ss) begin
            sum = {1'b0, ml} + {1'b0, sh};
            e = {1'b0, el};
            if (sum[MB]) begin
                sum = sum >> 1;
                e = e + 1'b1;
            end
            if (e[EB]) begin
                r.status = ST_OVERFLOW;
                r.result = {sl, {EB{1'b1}}, {MB{1'b1}}};
            end else begin
                r.result = fp_pack(sl, e, sum);
            end
        end else begin
            if (ml >= sh) begin
                diff = ml - sh; s = sl;
            end else begin
                diff = sh - ml; s = ss;
            end
            if (diff != 0) begin
                lz = 0;
                while (!diff[MB-1]) begin
                    diff = diff << 1;
                    lz++;
                end
                if (lz > int'(el)) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.result = {s, el - EB'(lz), diff};
                end
            end
        end
        return r;
    endfunction

    function automatic logic [WB-1:0] rand_float();
        logic [WB-1:0] f;
        int kind;
        f = WB'({$urandom, $urandom});
        kind = $urandom_range(0, 19);
        if (kind < 14) f[MB-1] = 1'b1;                     // normalized
        if (kind == 14) f[WB-2:0] = '0;                     // zero
        if (kind == 15) f[WB-2:MB] = EB'($urandom_range(250, 255));
        if (kind == 16) f[WB-2:MB] = EB'($urandom_range(0, 5));
        return f;
    endfunction

    // Operand b correlated with a so that alignment and cancellation are hit.
    function automatic logic [WB-1:0] rand_partner(logic [WB-1:0] a);
        logic [WB-1:0] b;
        b = rand_float();
        case ($urandom_range(0, 3))
            0: b[WB-2:MB] = a[WB-2:MB] + EB'($urandom_range(0, 3));
            1: begin
                b[WB-2:0] = a[WB-2:0];
                b[6'($urandom_range(0, 6))] ^= 1'b1;
            end
            2: b[WB-2:MB] = a[WB-2:MB] - EB'($urandom_range(20, 30));
            default: ;
        endcase
        return b;
    endfunction

    localparam logic [WB-1:0] ONE   = {1'b0, 8'd127, 24'h800000};
    localparam logic [WB-1:0] NONE  = {1'b1, 8'd127, 24'h800000};
    localparam logic [WB-1:0] MAXF  = {1'b0, 8'hff, 24'hffffff};
    localparam logic [WB-1:0] NZERO = {1'b1, 32'd0};
    localparam logic [WB-1:0] TINY  = {1'b0, 8'd0, 24'h800000};
    localparam logic [WB-1:0] TINY2 = {1'b0, 8'd0, 24'h800001};

    vec_t directed[] = '{
        '{OP_ADD, '0, '0, 1'b1, '{'0, ST_OK}},
        '{OP_SUB, NZERO, NZERO, 1'b1, '{'0, ST_OK}},
        '{OP_SUB, '0, ONE, 1'b1, '{NONE, ST_OK}},
        '{OP_ADD, '0, NONE, 1'b1, '{NONE, ST_OK}},
        '{OP_SUB, ONE, '0, 1'b1, '{ONE, ST_OK}},
        '{OP_SUB, ONE, ONE, 1'b1, '{'0, ST_OK}},
        '{OP_ADD, ONE, NONE, 1'b1, '{'0, ST_OK}},
        '{OP_ADD, MAXF, MAXF, 1'b1, '{MAXF, ST_OVERFLOW}},
        '{OP_SUB, {1'b1, 32'hffffffff}, MAXF, 1'b1, '{{1'b1, 32'hffffffff}, ST_OVERFLOW}},
        '{OP_ADD, ONE, ONE, 1'b1, '{{1'b0, 8'd128, 24'h800000}, ST_OK}},
        '{OP_ADD, ONE, {1'b0, 8'd90, 24'h800000}, 1'b1, '{ONE, ST_OK}},
        '{OP_SUB, TINY2, TINY, 1'b1, '{'0, ST_UNDERFLOW}},
        '{OP_ADD, {1'b0, 8'd3, 24'h000001}, {1'b0, 8'd3, 24'h000002}, 1'b0, '{'0, ST_OK}},
        '{OP_SUB, {1'b0, 8'd3, 24'h000001}, {1'b0, 8'd3, 24'h000004}, 1'b0, '{'0, ST_OK}},
        '{OP_SUB, ONE, {1'b0, 8'd126, 24'hffffff}, 1'b0, '{'0, ST_OK}},
        '{OP_ADD, {1'b1, 8'd200, 24'hc00000}, {1'b1, 8'd190, 24'hffffff}, 1'b0, '{'0, ST_OK}},
        '{OP_SUB, {1'b0, 8'd10, 24'h000003}, {1'b0, 8'd0, 24'h000002}, 1'b0, '{'0, ST_OK}},
        '{OP_ADD, {1'b0, 8'd0, 24'h000002}, {1'b1, 8'd10, 24'h000003}, 1'b0, '{'0, ST_OK}},
        '{OP_SUB, {1'b1, 32'hffffffff}, {1'b1, 8'h00, 24'h000001}, 1'b0, '{'0, ST_OK}},
        '{OP_ADD, {1'b0, 8'haa, 24'h555555}, {1'b1, 8'h55, 24'haaaaaa}, 1'b0, '{'0, ST_OK}}
    };

    task automatic send_transaction(logic op, logic [WB-1:0] a, logic [WB-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= IN_W'({b, a, op});
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Prediction at the input acceptance edge keeps the queue in order.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_q.push_back(fp_add_sub(s_axis_tdata[0], s_axis_tdata[WB:1],
                                            s_axis_tdata[2*WB:WB+1]));
    end

    always @(posedge i_clk) begin
        fp_result_t got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.result = m_axis_tdata[WB-1:0];
            got.status = t_status'(m_axis_tdata[WB+STATUS_BITS-1:WB]);
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction %h", got.result);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.result !== exp_r.result) begin
                    $error("result: expected %h actual %h", exp_r.result, got.result);
                    errors++;
                end
                if (got.status !== exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status, got.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n)
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("float_add_sub_unit test failed");
            $finish;
        end
    end

    // Directed rows with a typed result are also checked against the predictor.
    initial begin
        foreach (directed[i])
            if (directed[i].known &&
                fp_add_sub(directed[i].op, directed[i].a, directed[i].b) !== directed[i].res) begin
                $error("row %0d: predictor disagrees with table", i);
                errors++;
            end
    end

    initial begin
        logic [WB-1:0] a;
        int settle;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i])
            send_transaction(directed[i].op, directed[i].a, directed[i].b);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 55; recv_idle_pct = 25;
            end
            if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            a = rand_float();
            send_transaction($urandom_range(0, 1), a, rand_partner(a));
        end
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        settle = 0;
        while (settle < 20) begin
            @(posedge i_clk);
            settle++;
        end
        if (errors == 0)
            $display("float_add_sub_unit test passed");
        else
            $display("float_add_sub_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/fasu_pkg.sv
sv/fasu_align.sv
sv/fasu_norm.sv
sv/float_add_sub_unit.sv
sv/fasu_checker.sv
tb/sv/float_add_sub_unit_tb.sv
